>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the decoder sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/dhrd_pkg.sv
// ----------------------------------------------------------------------------
// dhrd_pkg
// Shared types, constants and exponent tables of the row decoder.
// ----------------------------------------------------------------------------
package dhrd_pkg;

   // Row layout
   localparam int STORED      = 22;
   localparam int OBJ_POS     = 8;
   localparam int COLOR_POS   = 9;
   localparam int NUM_POS     = 13;
   localparam int COLOR_COUNT = 4;
   localparam int NUM_COUNT   = 9;
   localparam int POINT_LANES = 8;
   localparam int POINTS      = 4;

   // Arithmetic sizes
   localparam int DIV_STEPS = 33;
   localparam int ADDR_W    = 5;
   localparam int LANE_W    = 4;
   localparam int CNT_W     = 6;
   localparam int SUM_W     = 20;
   localparam int QUO_W     = 33;
   localparam int PROB_W    = 16;
   localparam int EXP_W     = 17;
   localparam int EXP_LIMIT = 3072;

   // Register indexes
   localparam logic [1:0] CSR_ROW_LENGTH = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [1:0] CSR_INV_SCALE  = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_WRITE,
      OP_ARG_FIRST,
      OP_ARG_STEP,
      OP_SUM_CLR,
      OP_EXP_DIFF,
      OP_EXP_ABS,
      OP_EXP_MUL1,
      OP_EXP_MUL2,
      OP_DIV_SOFT,
      OP_DIV_SIG,
      OP_DIV_STEP,
      OP_SAVE_COLOR,
      OP_SAVE_NUMBER,
      OP_SAVE_SIG,
      OP_CONF1,
      OP_CONF2,
      OP_SCALE_MUL,
      OP_SCALE_SAT,
      OP_BOX,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic [ADDR_W-1:0]   addr;
      logic [LANE_W-1:0]   lane;
   } dp_cmd_type;

   typedef struct packed {
      logic conf_pass;
   } dp_status_type;

   // exp(-n) for the integer part, Q.16
   function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] idx);
      case (idx)
         4'd0:    exp_int = 17'd65536;
         4'd1:    exp_int = 17'd24109;
         4'd2:    exp_int = 17'd8869;
         4'd3:    exp_int = 17'd3263;
         4'd4:    exp_int = 17'd1200;
         4'd5:    exp_int = 17'd442;
         4'd6:    exp_int = 17'd162;
         4'd7:    exp_int = 17'd60;
         4'd8:    exp_int = 17'd22;
         4'd9:    exp_int = 17'd8;
         4'd10:   exp_int = 17'd3;
         4'd11:   exp_int = 17'd1;
         default: exp_int = 17'd0;
      endcase
   endfunction

   // exp(-n/16) for the upper fraction nibble, Q.16
   function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] idx);
      case (idx)
         4'd0:    exp_hi = 17'd65536;
         4'd1:    exp_hi = 17'd61565;
         4'd2:    exp_hi = 17'd57835;
         4'd3:    exp_hi = 17'd54331;
         4'd4:    exp_hi = 17'd51039;
         4'd5:    exp_hi = 17'd47947;
         4'd6:    exp_hi = 17'd45042;
         4'd7:    exp_hi = 17'd42313;
         4'd8:    exp_hi = 17'd39750;
         4'd9:    exp_hi = 17'd37341;
         4'd10:   exp_hi = 17'd35079;
         4'd11:   exp_hi = 17'd32954;
         4'd12:   exp_hi = 17'd30957;
         4'd13:   exp_hi = 17'd29081;
         4'd14:   exp_hi = 17'd27319;
         4'd15:   exp_hi = 17'd25664;
         default: exp_hi = 17'd0;
      endcase
   endfunction

   // exp(-n/256) for the lower fraction nibble, Q.16
   function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] idx);
      case (idx)
         4'd0:    exp_lo = 17'd65536;
         4'd1:    exp_lo = 17'd65280;
         4'd2:    exp_lo = 17'd65026;
         4'd3:    exp_lo = 17'd64772;
         4'd4:    exp_lo = 17'd64520;
         4'd5:    exp_lo = 17'd64268;
         4'd6:    exp_lo = 17'd64018;
         4'd7:    exp_lo = 17'd63768;
         4'd8:    exp_lo = 17'd63520;
         4'd9:    exp_lo = 17'd63272;
         4'd10:   exp_lo = 17'd63025;
         4'd11:   exp_lo = 17'd62780;
         4'd12:   exp_lo = 17'd62535;
         4'd13:   exp_lo = 17'd62291;
         4'd14:   exp_lo = 17'd62048;
         4'd15:   exp_lo = 17'd61806;
         default: exp_lo = 17'd0;
      endcase
   endfunction

endpackage

>>> src/dhrd_datapath.sv
// ----------------------------------------------------------------------------
// dhrd_datapath
// Row store, exponent unit, shared divider, confidence and keypoint scaling.
// ----------------------------------------------------------------------------
module dhrd_datapath #(
   parameter int VALUE_BITS = 24
) (
   input  logic                           clock,
   input  dhrd_pkg::dp_cmd_type           cmd,
   input  logic signed [VALUE_BITS-1:0]   row_value,
   input  logic [15:0]                    threshold,
   input  logic [23:0]                    inv_scale,
   output dhrd_pkg::dp_status_type        status,
   output logic [1:0]                     point_index,
   output logic signed [VALUE_BITS-1:0]   point_x,
   output logic signed [VALUE_BITS-1:0]   point_y,
   output logic                           last_point,
   output logic [15:0]                    confidence,
   output logic [1:0]                     color_code,
   output logic [2:0]                     number_code,
   output logic                           large_armor,
   output logic signed [15:0]             box_left,
   output logic signed [15:0]             box_top,
   output logic [15:0]                    box_width,
   output logic [15:0]                    box_height
);
   import dhrd_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int PW = VALUE_BITS + 25;
   localparam logic signed [PW-1:0] SAT_HI = {{(PW-VB+1){1'b0}}, {(VB-1){1'b1}}};
   localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

   // Truncate a Q.8 value toward zero and clamp to 16 bits signed
   function automatic logic [15:0] trunc_sat16(input logic signed [VB-1:0] v);
      logic signed [VB:0] ext;
      logic [VB:0]        mag;
      logic [VB:0]        t;
      logic [VB:0]        neg_t;
      ext   = v;
      mag   = v[VB-1] ? $unsigned(-ext) : $unsigned(ext);
      t     = mag >> 8;
      neg_t = -t;
      if (!v[VB-1]) begin
         trunc_sat16 = (t > (VB+1)'(32767)) ? 16'h7FFF : t[15:0];
      end else begin
         trunc_sat16 = (t > (VB+1)'(32768)) ? 16'h8000 : neg_t[15:0];
      end
   endfunction

   // Integer part of a nonnegative span, clamped to 16 bits unsigned
   function automatic logic [15:0] span_sat16(input logic [VB:0] diff);
      logic [VB:0] t;
      t = diff >> 8;
      span_sat16 = (t > (VB+1)'(65535)) ? 16'hFFFF : t[15:0];
   endfunction

   logic signed [VB-1:0]  store_ff [STORED];
   logic signed [VB-1:0]  rd;
   logic signed [VB-1:0]  best_ff;
   logic [3:0]            best_idx_ff;
   logic [VB:0]           d_ff;
   logic [EXP_W-1:0]      r1_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [QUO_W-1:0]      q_ff;
   logic [SUM_W-1:0]      rem_ff;
   logic [SUM_W-1:0]      divisor_ff;
   logic [PROB_W-1:0]     pc_ff, pn_ff, sig_ff, conf_ff;
   logic [1:0]            color_ff;
   logic [3:0]            num_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [VB-1:0]  pt_ff [POINT_LANES];
   logic signed [VB-1:0]  mnx_ff, mxx_ff, mny_ff, mxy_ff;
   logic [15:0]           left_ff, top_ff, width_ff, height_ff;
   logic [1:0]            out_idx_ff;
   logic signed [VB-1:0]  out_x_ff, out_y_ff;

   logic signed [VB:0]    rd_ext, best_ext;
   logic                  exp_zero;
   logic [2*EXP_W-1:0]    p1, p2;
   logic [SUM_W:0]        div_t;
   logic                  div_ge;
   logic [PROB_W-1:0]     quo_cap;
   logic [2*PROB_W:0]     conf_prod;
   logic [PROB_W-1:0]     conf_mul_b;
   logic signed [PW-1:0]  mul_a, mul_b, prod_in, rounded;
   logic signed [VB-1:0]  sat_v;
   logic [2:0]            lane3;
   logic [VB:0]           span_x, span_y;

   assign rd       = store_ff[cmd.addr];
   assign rd_ext   = rd;
   assign best_ext = best_ff;
   assign lane3    = cmd.lane[2:0];

   // Exponent products, rounded half up after each multiply
   assign exp_zero = d_ff >= (VB+1)'(EXP_LIMIT);
   assign p1 = exp_int(d_ff[11:8]) * exp_hi(d_ff[7:4]) + (2*EXP_W)'(32768);
   assign p2 = r1_ff * exp_lo(d_ff[3:0]) + (2*EXP_W)'(32768);

   // One restoring divider step
   assign div_t  = {rem_ff, q_ff[QUO_W-1]};
   assign div_ge = div_t >= {1'b0, divisor_ff};
   assign quo_cap = (|q_ff[QUO_W-1:PROB_W]) ? {PROB_W{1'b1}} : q_ff[PROB_W-1:0];

   // Confidence multiply: first by color, then by number probability
   assign conf_mul_b = (cmd.op == OP_CONF1) ? pc_ff : pn_ff;
   assign conf_prod  = ((cmd.op == OP_CONF1) ? sig_ff : conf_ff) * conf_mul_b
                       + (2*PROB_W+1)'(32768);

   // Keypoint scaling and saturation
   assign mul_a   = rd;
   assign mul_b   = $signed({1'b0, inv_scale});
   assign prod_in = mul_a * mul_b;
   assign rounded = (prod_ff + PW'(32768)) >>> 16;
   assign sat_v   = (rounded > SAT_HI) ? SAT_HI[VB-1:0] :
                    (rounded < SAT_LO) ? SAT_LO[VB-1:0] : rounded[VB-1:0];

   assign span_x = $unsigned((VB+1)'(mxx_ff) - (VB+1)'(mnx_ff));
   assign span_y = $unsigned((VB+1)'(mxy_ff) - (VB+1)'(mny_ff));

   // Store incoming row elements
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         store_ff[cmd.addr] <= row_value;
      end
   end

   // Arithmetic sequence driven by the controller
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ARG_FIRST: begin
            best_ff     <= rd;
            best_idx_ff <= '0;
            sum_ff      <= '0;
         end
         OP_ARG_STEP: begin
            if (rd > best_ff) begin
               best_ff     <= rd;
               best_idx_ff <= cmd.lane;
            end
         end
         OP_SUM_CLR: begin
            sum_ff <= '0;
         end
         OP_EXP_DIFF: begin
            d_ff <= $unsigned(best_ext - rd_ext);
         end
         OP_EXP_ABS: begin
            d_ff <= rd[VB-1] ? $unsigned(-rd_ext) : $unsigned(rd_ext);
         end
         OP_EXP_MUL1: begin
            r1_ff <= exp_zero ? '0 : p1[EXP_W+15:16];
         end
         OP_EXP_MUL2: begin
            sum_ff <= sum_ff + SUM_W'(p2[EXP_W+15:16]);
         end
         OP_DIV_SOFT: begin
            q_ff       <= {1'b1, {(QUO_W-1){1'b0}}};
            rem_ff     <= '0;
            divisor_ff <= sum_ff;
         end
         OP_DIV_SIG: begin
            q_ff       <= rd[VB-1] ? {sum_ff[QUO_W-PROB_W-1:0], {PROB_W{1'b0}}}
                                   : {1'b1, {(QUO_W-1){1'b0}}};
            rem_ff     <= '0;
            divisor_ff <= sum_ff + SUM_W'(65536);
         end
         OP_DIV_STEP: begin
            rem_ff <= div_ge ? div_t[SUM_W-1:0] - divisor_ff : div_t[SUM_W-1:0];
            q_ff   <= {q_ff[QUO_W-2:0], div_ge};
         end
         OP_SAVE_COLOR: begin
            pc_ff    <= quo_cap;
            color_ff <= best_idx_ff[1:0];
         end
         OP_SAVE_NUMBER: begin
            pn_ff  <= quo_cap;
            num_ff <= best_idx_ff;
         end
         OP_SAVE_SIG: begin
            sig_ff <= quo_cap;
         end
         OP_CONF1, OP_CONF2: begin
            conf_ff <= conf_prod[2*PROB_W-1:PROB_W];
         end
         OP_SCALE_MUL: begin
            prod_ff <= prod_in;
         end
         OP_SCALE_SAT: begin
            pt_ff[lane3] <= sat_v;
            if (!lane3[0]) begin
               if (lane3[2:1] == 2'd0) begin
                  mnx_ff <= sat_v;
                  mxx_ff <= sat_v;
               end else begin
                  if (sat_v < mnx_ff) mnx_ff <= sat_v;
                  if (sat_v > mxx_ff) mxx_ff <= sat_v;
               end
            end else begin
               if (lane3[2:1] == 2'd0) begin
                  mny_ff <= sat_v;
                  mxy_ff <= sat_v;
               end else begin
                  if (sat_v < mny_ff) mny_ff <= sat_v;
                  if (sat_v > mxy_ff) mxy_ff <= sat_v;
               end
            end
         end
         OP_BOX: begin
            left_ff   <= trunc_sat16(mnx_ff);
            top_ff    <= trunc_sat16(mny_ff);
            width_ff  <= span_sat16(span_x);
            height_ff <= span_sat16(span_y);
         end
         OP_EMIT: begin
            out_idx_ff <= cmd.lane[1:0];
            out_x_ff   <= pt_ff[{cmd.lane[1:0], 1'b0}];
            out_y_ff   <= pt_ff[{cmd.lane[1:0], 1'b1}];
         end
         default: begin
         end
      endcase
   end

   assign status.conf_pass = conf_ff >= threshold;

   assign point_index = out_idx_ff;
   assign point_x     = out_x_ff;
   assign point_y     = out_y_ff;
   assign last_point  = out_idx_ff == 2'(POINTS-1);
   assign confidence  = conf_ff;
   assign color_code  = color_ff;
   assign number_code = (num_ff >= 4'd7) ? 3'd7 : num_ff[2:0];
   assign large_armor = (num_ff == 4'd0) || (num_ff == 4'd1) || (num_ff == 4'd8);
   assign box_left    = left_ff;
   assign box_top     = top_ff;
   assign box_width   = width_ff;
   assign box_height  = height_ff;

endmodule

>>> src/dhrd_ctrl.sv
// ----------------------------------------------------------------------------
// dhrd_ctrl
// Sequencer: row collection, decode steps and result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhrd_ctrl #(
   parameter int MAX_ROW_LENGTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tlast,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [6:0]               row_length,
   input  dhrd_pkg::dp_status_type  status,
   output dhrd_pkg::dp_cmd_type     cmd
);
   import dhrd_pkg::*;

   localparam int IDX_W = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
   localparam int CW    = (LEN_W > 7) ? LEN_W : 7;

   typedef enum logic [4:0] {
      S_COLLECT, S_ARG, S_EXP_D, S_EXP_M1, S_EXP_M2, S_DIV_LOAD, S_DIV, S_SAVE,
      S_SIG_CLR, S_CONF1, S_CONF2, S_CHECK, S_SCALE_MUL, S_SCALE_SAT, S_BOX,
      S_EMIT_LOAD, S_EMIT_WAIT
   } state_type;

   typedef enum logic [1:0] {G_COLOR, G_NUMBER, G_SIG} group_type;

   state_type          state_ff, state_in;
   group_type          grp_ff, grp_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;

   logic [ADDR_W-1:0]  base;
   logic [CNT_W-1:0]   n_last;
   logic [CW-1:0]      len_raw, len_clamped, idx_next;
   logic               accept, row_end;

   // Clamp the row length and detect the last element of a row
   assign len_raw     = CW'(row_length);
   assign len_clamped = (len_raw < CW'(STORED)) ? CW'(STORED) :
                        (len_raw > CW'(MAX_ROW_LENGTH)) ? CW'(MAX_ROW_LENGTH) : len_raw;
   assign idx_next    = CW'(idx_ff) + CW'(1);
   assign row_end     = idx_next >= len_clamped;
   assign accept      = req_tvalid && req_tready;

   assign base   = (grp_ff == G_COLOR) ? ADDR_W'(COLOR_POS) : ADDR_W'(NUM_POS);
   assign n_last = (grp_ff == G_COLOR) ? CNT_W'(COLOR_COUNT - 1) : CNT_W'(NUM_COUNT - 1);

   assign req_tready = state_ff == S_COLLECT;
   assign rsp_tvalid = valid_ff;

   // Decode commands for the datapath
   always_comb begin
      cmd.op   = OP_NONE;
      cmd.addr = base + cnt_ff[ADDR_W-1:0];
      cmd.lane = cnt_ff[LANE_W-1:0];
      case (state_ff)
         S_COLLECT: begin
            cmd.addr = idx_ff[ADDR_W-1:0];
            if (req_tvalid && (CW'(idx_ff) < CW'(STORED))) cmd.op = OP_WRITE;
         end
         S_ARG:       cmd.op = (cnt_ff == '0) ? OP_ARG_FIRST : OP_ARG_STEP;
         S_EXP_D: begin
            if (grp_ff == G_SIG) begin
               cmd.op   = OP_EXP_ABS;
               cmd.addr = ADDR_W'(OBJ_POS);
            end else begin
               cmd.op = OP_EXP_DIFF;
            end
         end
         S_EXP_M1:    cmd.op = OP_EXP_MUL1;
         S_EXP_M2:    cmd.op = OP_EXP_MUL2;
         S_DIV_LOAD: begin
            if (grp_ff == G_SIG) begin
               cmd.op   = OP_DIV_SIG;
               cmd.addr = ADDR_W'(OBJ_POS);
            end else begin
               cmd.op = OP_DIV_SOFT;
            end
         end
         S_DIV:       cmd.op = OP_DIV_STEP;
         S_SAVE: begin
            case (grp_ff)
               G_COLOR:  cmd.op = OP_SAVE_COLOR;
               G_NUMBER: cmd.op = OP_SAVE_NUMBER;
               default:  cmd.op = OP_SAVE_SIG;
            endcase
         end
         S_SIG_CLR:   cmd.op = OP_SUM_CLR;
         S_CONF1:     cmd.op = OP_CONF1;
         S_CONF2:     cmd.op = OP_CONF2;
         S_SCALE_MUL: begin
            cmd.op   = OP_SCALE_MUL;
            cmd.addr = cnt_ff[ADDR_W-1:0];
         end
         S_SCALE_SAT: cmd.op = OP_SCALE_SAT;
         S_BOX:       cmd.op = OP_BOX;
         S_EMIT_LOAD: cmd.op = OP_EMIT;
         default:     cmd.op = OP_NONE;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      case (state_ff)
         S_COLLECT: begin
            if (accept) begin
               if (row_end) begin
                  idx_in   = '0;
                  cnt_in   = '0;
                  grp_in   = G_COLOR;
                  state_in = S_ARG;
               end else if (req_tlast) begin
                  idx_in = '0;
               end else begin
                  idx_in = idx_next[IDX_W-1:0];
               end
            end
         end
         S_ARG: begin
            if (cnt_ff == n_last) begin
               cnt_in   = '0;
               state_in = S_EXP_D;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_EXP_D:  state_in = S_EXP_M1;
         S_EXP_M1: state_in = S_EXP_M2;
         S_EXP_M2: begin
            if ((grp_ff == G_SIG) || (cnt_ff == n_last)) begin
               cnt_in   = '0;
               state_in = S_DIV_LOAD;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_EXP_D;
            end
         end
         S_DIV_LOAD: begin
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_SAVE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_SAVE: begin
            cnt_in = '0;
            case (grp_ff)
               G_COLOR: begin
                  grp_in   = G_NUMBER;
                  state_in = S_ARG;
               end
               G_NUMBER: begin
                  grp_in   = G_SIG;
                  state_in = S_SIG_CLR;
               end
               default:  state_in = S_CONF1;
            endcase
         end
         S_SIG_CLR: state_in = S_EXP_D;
         S_CONF1:   state_in = S_CONF2;
         S_CONF2:   state_in = S_CHECK;
         S_CHECK: begin
            cnt_in   = '0;
            state_in = status.conf_pass ? S_SCALE_MUL : S_COLLECT;
         end
         S_SCALE_MUL: state_in = S_SCALE_SAT;
         S_SCALE_SAT: begin
            if (cnt_ff == CNT_W'(POINT_LANES - 1)) begin
               state_in = S_BOX;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_SCALE_MUL;
            end
         end
         S_BOX: begin
            cnt_in   = '0;
            state_in = S_EMIT_LOAD;
         end
         S_EMIT_LOAD: begin
            valid_in = 1'b1;
            state_in = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               if (cnt_ff == CNT_W'(POINTS - 1)) begin
                  state_in = S_COLLECT;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = S_EMIT_LOAD;
               end
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         grp_ff   <= G_COLOR;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   `ASSERT_HOLDS(a_one_side_open, clock, reset, !(req_tready && rsp_tvalid), "input open while result pending")
   `ASSERT_NEXT(a_row_end_stalls, clock, reset, accept && row_end, !req_tready, "input not closed at row end")
   `ASSERT_NEXT(a_last_reopens, clock, reset, rsp_tvalid && rsp_tready && (cnt_ff == CNT_W'(POINTS - 1)), req_tready, "input not reopened after last result")

endmodule

>>> src/detection_head_row_decoder_core.sv
// ----------------------------------------------------------------------------
// detection_head_row_decoder_core
// Keypoint detection head row decoder: collects rows, scores them and emits
// four keypoint results for each row that passes the confidence threshold.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req       in         tvalid / tready    tdata row_value, tlast end_of_frame
//  rsp       out        tvalid / tready    tdata box and point fields,
//                                          tuser point_index, tlast last_point
//  csr       in         write_enable       csr_index, csr_wdata
//
//  Row values enter at one per cycle while the input is open. After the last
//  value of a row the input closes while the sequencer decodes: through the
//  exponent unit and the shared 33-step divider, then keypoint scaling and box
//  work for a passing row, then a load step plus the handshake for each result.
//  Reset is synchronous; the row store is not cleared. A stalled result holds
//  the output register and the input stays closed until the fourth is taken.
// ----------------------------------------------------------------------------
module detection_head_row_decoder_core #(
   parameter int VALUE_BITS     = 24,
   parameter int MAX_ROW_LENGTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata,   // row_value
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // point_x, point_y, confidence, color_code, number_code, large_armor,
   // box_left, box_top, box_width, box_height
   output logic [((2*VALUE_BITS+86+7)/8)*8-1:0] rsp_tdata,
   output logic [1:0]           rsp_tuser,   // point_index
   output logic                 rsp_tlast,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_wdata
);
   import dhrd_pkg::*;

   localparam int VB    = VALUE_BITS;
   localparam int OUT_W = ((2*VALUE_BITS+86+7)/8)*8;

   logic [6:0]              row_length_ff;
   logic [15:0]             threshold_ff;
   logic [23:0]             inv_scale_ff;
   dp_cmd_type              cmd;
   dp_status_type           status;
   logic signed [VB-1:0]    point_x, point_y;
   logic [15:0]             confidence, box_width, box_height;
   logic signed [15:0]      box_left, box_top;
   logic [1:0]              color_code;
   logic [2:0]              number_code;
   logic                    large_armor;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= 7'd22;
         threshold_ff  <= 16'd16384;
         inv_scale_ff  <= 24'd65536;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_LENGTH: row_length_ff <= csr_wdata[6:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[15:0];
            CSR_INV_SCALE:  inv_scale_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dhrd_ctrl #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .row_length (row_length_ff),
      .status     (status),
      .cmd        (cmd)
   );

   dhrd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .row_value   (req_tdata[VB-1:0]),
      .threshold   (threshold_ff),
      .inv_scale   (inv_scale_ff),
      .status      (status),
      .point_index (rsp_tuser),
      .point_x     (point_x),
      .point_y     (point_y),
      .last_point  (rsp_tlast),
      .confidence  (confidence),
      .color_code  (color_code),
      .number_code (number_code),
      .large_armor (large_armor),
      .box_left    (box_left),
      .box_top     (box_top),
      .box_width   (box_width),
      .box_height  (box_height)
   );

   // Pack result fields, lowest first, padded to whole bytes
   assign rsp_tdata = OUT_W'({box_height, box_width, box_top, box_left, large_armor,
                              number_code, color_code, confidence, point_y, point_x});

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams detector rows into the row decoder with random gaps and back
// pressure, predicts each passing detection's four keypoint results and
// checks every returned result field by field.
// ----------------------------------------------------------------------------
module testbench;
   import dhrd_pkg::*;

   localparam int VALUE_BITS     = 24;
   localparam int MAX_ROW_LENGTH = 64;
   localparam int MIN_ROW_LENGTH = 22;
   localparam int QUIET_CYCLES   = 400;
   localparam int CYCLE_LIMIT    = 1500000;
   localparam int ITEM_TARGET    = 170;

   typedef enum int {ROW_SCORED, ROW_NOISE, ROW_HIGH, ROW_LOW, ROW_TIED} row_kind_type;

   typedef struct {
      logic [23:0] value;
      logic        eof;
   } row_request_type;

   typedef struct {
      logic [1:0]  point_index;
      logic [23:0] point_x;
      logic [23:0] point_y;
      logic        last_point;
      logic [15:0] confidence;
      logic [1:0]  color_code;
      logic [2:0]  number_code;
      logic        large_armor;
      logic [15:0] box_left;
      logic [15:0] box_top;
      logic [15:0] box_width;
      logic [15:0] box_height;
   } keypoint_result_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [23:0]   req_tdata;    // row_value
   logic          req_tlast;
   logic          rsp_tvalid;
   logic          rsp_tready;
   // point_x, point_y, confidence, color_code, number_code, large_armor,
   // box_left, box_top, box_width, box_height
   logic [135:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;    // point_index
   logic          rsp_tlast;
   logic          csr_write_enable;
   logic [1:0]    csr_index;
   logic [23:0]   csr_wdata;

   row_request_type     pending_values[$];
   keypoint_result_type expected_points[$];
   keypoint_result_type head_point;

   // Decoder image: register copies, stored row and element counter
   int unsigned cfg_row_length;
   int unsigned cfg_threshold;
   longint      cfg_inv_scale;
   longint      row_image[22];
   int unsigned element_count;

   longint exp_int_tab[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
   longint exp_hi_tab[16]  = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                               39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
   longint exp_lo_tab[16]  = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                               63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

   int fail_count;
   int results_seen;
   int items_sent;
   int cycle_count;
   int burst_left;
   int gap_left;
   int stall_mode;
   int stall_left;

   detection_head_row_decoder_core #(
      .VALUE_BITS     (VALUE_BITS),
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // exp(-d) for d >= 0 in Q.8, result Q.16
   function automatic longint exp_neg_q16(longint d);
      longint r;
      if (d >= 3072) return 0;
      r = (exp_int_tab[d >> 8] * exp_hi_tab[(d >> 4) & 15] + 32768) >> 16;
      r = (r * exp_lo_tab[d & 15] + 32768) >> 16;
      return r;
   endfunction

   // top softmax probability over stored logits, first index wins a tie
   function automatic longint top_probability(int base, int count, output int winner);
      longint sum;
      longint p;
      winner = 0;
      sum = 0;
      for (int j = 1; j < count; j++)
         if (row_image[base + j] > row_image[base + winner]) winner = j;
      for (int j = 0; j < count; j++)
         sum += exp_neg_q16(row_image[base + winner] - row_image[base + j]);
      p = (64'sd1 << 32) / sum;
      return (p > 65535) ? 65535 : p;
   endfunction

   function automatic longint sigmoid_q16(longint x);
      longint e;
      longint p;
      if (x >= 0) begin
         p = (64'sd1 << 32) / (65536 + exp_neg_q16(x));
      end else begin
         e = exp_neg_q16(-x);
         p = (e << 16) / (65536 + e);
      end
      return (p > 65535) ? 65535 : p;
   endfunction

   // multiply by the inverse scale, round half up, saturate to the value width
   function automatic longint scale_coord(longint v);
      longint r;
      r = (v * cfg_inv_scale + 32768) >>> 16;
      if (r < -(64'sd1 <<< 23)) r = -(64'sd1 <<< 23);
      if (r > (64'sd1 <<< 23) - 1) r = (64'sd1 <<< 23) - 1;
      return r;
   endfunction

   function automatic longint whole_pixels(longint v);
      return (v >= 0) ? (v >> 8) : -((-v) >> 8);
   endfunction

   function automatic longint clip16(longint v);
      return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
   endfunction

   // score the stored row and queue its four keypoint results if it passes
   task automatic decode_stored_row();
      int color;
      int number;
      longint p_color;
      longint p_number;
      longint conf;
      longint px[4];
      longint py[4];
      longint min_x, min_y, max_x, max_y, span_x, span_y;
      keypoint_result_type pt;
      p_color  = top_probability(COLOR_POS, COLOR_COUNT, color);
      p_number = top_probability(NUM_POS, NUM_COUNT, number);
      conf = (sigmoid_q16(row_image[OBJ_POS]) * p_color + 32768) >> 16;
      conf = (conf * p_number + 32768) >> 16;
      if (conf < cfg_threshold) return;
      for (int k = 0; k < 4; k++) begin
         px[k] = scale_coord(row_image[2 * k]);
         py[k] = scale_coord(row_image[2 * k + 1]);
      end
      min_x = px[0]; max_x = px[0]; min_y = py[0]; max_y = py[0];
      for (int k = 1; k < 4; k++) begin
         if (px[k] < min_x) min_x = px[k];
         if (px[k] > max_x) max_x = px[k];
         if (py[k] < min_y) min_y = py[k];
         if (py[k] > max_y) max_y = py[k];
      end
      span_x = whole_pixels(max_x - min_x);
      span_y = whole_pixels(max_y - min_y);
      if (span_x > 65535) span_x = 65535;
      if (span_y > 65535) span_y = 65535;
      for (int k = 0; k < 4; k++) begin
         pt.point_index = k[1:0];
         pt.point_x     = px[k][23:0];
         pt.point_y     = py[k][23:0];
         pt.last_point  = (k == 3);
         pt.confidence  = conf[15:0];
         pt.color_code  = color[1:0];
         pt.number_code = (number >= 7) ? 3'd7 : number[2:0];
         pt.large_armor = (number == 0 || number == 1 || number == 8);
         pt.box_left    = 16'(clip16(whole_pixels(min_x)));
         pt.box_top     = 16'(clip16(whole_pixels(min_y)));
         pt.box_width   = span_x[15:0];
         pt.box_height  = span_y[15:0];
         expected_points = {expected_points, pt};
      end
   endtask

   function automatic int unsigned active_length();
      if (cfg_row_length < MIN_ROW_LENGTH) return MIN_ROW_LENGTH;
      if (cfg_row_length > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
      return cfg_row_length;
   endfunction

   // advance the decoder image by one accepted request
   task automatic absorb_value(logic [23:0] raw, logic eof);
      bit row_end;
      if (element_count < STORED) row_image[element_count] = longint'($signed(raw));
      row_end = (element_count + 1 >= active_length());
      if (row_end) decode_stored_row();
      element_count = (row_end || eof) ? 0 : element_count + 1;
   endtask

   task automatic check_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) absorb_value(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_values.size() > 0) begin
               req_tdata  <= pending_values[0].value;
               req_tlast  <= pending_values[0].eof;
               req_tvalid <= 1'b1;
               void'(pending_values.pop_front());
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------ receiver and check
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode = 0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $error("result with no detection pending: point_index %0d", rsp_tuser);
               fail_count++;
            end else begin
               head_point = expected_points.pop_front();
               check_field("point_index", head_point.point_index, rsp_tuser);
               check_field("point_x",     head_point.point_x,     rsp_tdata[23:0]);
               check_field("point_y",     head_point.point_y,     rsp_tdata[47:24]);
               check_field("last_point",  head_point.last_point,  rsp_tlast);
               check_field("confidence",  head_point.confidence,  rsp_tdata[63:48]);
               check_field("color_code",  head_point.color_code,  rsp_tdata[65:64]);
               check_field("number_code", head_point.number_code, rsp_tdata[68:66]);
               check_field("large_armor", head_point.large_armor, rsp_tdata[69]);
               check_field("box_left",    head_point.box_left,    rsp_tdata[85:70]);
               check_field("box_top",     head_point.box_top,     rsp_tdata[101:86]);
               check_field("box_width",   head_point.box_width,   rsp_tdata[117:102]);
               check_field("box_height",  head_point.box_height,  rsp_tdata[133:118]);
               results_seen++;
            end
         end
         // switch stall pattern every so often
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= cycle_count[0];
            2: rsp_tready <= ($urandom_range(0, 99) < 60);
            default: rsp_tready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------ watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------ stimulus
   function automatic logic [23:0] pick_coord();
      if ($urandom_range(0, 9) == 0) return 24'($urandom());
      return 24'($signed($urandom_range(0, 131072)) - 65536);
   endfunction

   function automatic logic [23:0] small_logit();
      return 24'($signed($urandom_range(0, 2048)) - 1024);
   endfunction

   // queue one row; winners below zero are picked at random
   task automatic queue_row(row_kind_type kind, int unsigned len, int unsigned cut, bit eof,
                            int color_win = -1, int number_win = -1);
      logic [23:0]     vals[22];
      logic [23:0]     v;
      int              top;
      row_request_type item;
      for (int i = 0; i < 22; i++) begin
         case (kind)
            ROW_HIGH:  vals[i] = 24'h7FFFFF;
            ROW_LOW:   vals[i] = 24'h800000;
            ROW_TIED:  vals[i] = (i < OBJ_POS) ? pick_coord() : 24'd512;
            ROW_NOISE: vals[i] = 24'($urandom());
            default:   vals[i] = (i < OBJ_POS) ? pick_coord() : small_logit();
         endcase
      end
      if (kind == ROW_SCORED) begin
         vals[OBJ_POS] = 24'($signed($urandom_range(0, 2560)) - 512);
         if (color_win < 0) color_win = $urandom_range(0, 3);
         if (number_win < 0) number_win = $urandom_range(0, 8);
         top = $urandom_range(0, 3072) - 1024 + (($urandom_range(0, 7) == 0) ? 0 : 2048);
         vals[COLOR_POS + color_win] = 24'(top);
         vals[NUM_POS + number_win]  = 24'(top + $urandom_range(0, 1024));
      end
      for (int i = 0; i < cut; i++) begin
         v = (i < 22) ? vals[i] : 24'($urandom());
         item.value = v;
         item.eof   = (eof && i == cut - 1);
         pending_values = {pending_values, item};
         items_sent++;
      end
   endtask

   // wait for the block to drain, then let a possible silent decode finish
   task automatic drain();
      do @(negedge clock);
      while (pending_values.size() != 0 || req_tvalid || expected_points.size() != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      case (idx)
         CSR_ROW_LENGTH: cfg_row_length = value[6:0];
         CSR_THRESHOLD:  cfg_threshold  = value[15:0];
         CSR_INV_SCALE:  cfg_inv_scale  = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned     len;
      int unsigned     pick;
      int              phase;
      row_request_type extra;
      fail_count = 0; results_seen = 0; items_sent = 0; cycle_count = 0;
      cfg_row_length = 22; cfg_threshold = 16384; cfg_inv_scale = 65536;
      element_count = 0;
      for (int i = 0; i < 22; i++) row_image[i] = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ROW_LENGTH;
      csr_wdata        = '0;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0; rsp_tready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // extremes, ties, class corners and framing cases at reset settings
      queue_row(ROW_HIGH, 22, 22, 1'b0);
      queue_row(ROW_LOW, 22, 22, 1'b0);
      queue_row(ROW_TIED, 22, 22, 1'b0);
      queue_row(ROW_SCORED, 22, 22, 1'b0, 3, 8);
      queue_row(ROW_SCORED, 22, 10, 1'b1);
      queue_row(ROW_SCORED, 22, 22, 1'b1, 1, 7);
      drain();

      // zero scale, open threshold, short row length clamped up
      write_reg(CSR_THRESHOLD, 24'd0);
      write_reg(CSR_INV_SCALE, 24'd0);
      write_reg(CSR_ROW_LENGTH, 24'd5);
      queue_row(ROW_SCORED, 22, 22, 1'b0, 2, 0);
      drain();

      // long row length clamped down, largest scale, then lower the row length mid-row
      write_reg(CSR_INV_SCALE, 24'hFFFFFF);
      write_reg(CSR_ROW_LENGTH, 24'd127);
      queue_row(ROW_SCORED, 64, 26, 1'b0);
      drain();
      write_reg(CSR_ROW_LENGTH, 24'd22);
      extra.value = 24'($urandom());
      extra.eof   = 1'b0;
      pending_values = {pending_values, extra};
      items_sent++;
      drain();

      // random phases: new settings, then mostly well-formed rows
      phase = 0;
      while (items_sent < ITEM_TARGET && phase < 60) begin
         pick = $urandom_range(0, 9);
         write_reg(CSR_ROW_LENGTH, (pick < 6) ? 24'd22 :
                   (pick == 9) ? 24'($urandom_range(0, 127)) : 24'($urandom_range(22, 64)));
         pick = $urandom_range(0, 9);
         write_reg(CSR_THRESHOLD, (pick == 0) ? 24'd0 : (pick == 1) ? 24'd65535 :
                   24'($urandom_range(0, 40000)));
         pick = $urandom_range(0, 9);
         write_reg(CSR_INV_SCALE, (pick == 0) ? 24'($urandom()) : (pick == 1) ? 24'd1 :
                   24'($urandom_range(32768, 131072)));
         len = active_length();
         for (int r = 0; r < 2; r++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
               queue_row(ROW_SCORED, len, len, ($urandom_range(0, 4) == 0));
            else if (pick < 17)
               queue_row(ROW_NOISE, len, len, ($urandom_range(0, 4) == 0));
            else
               queue_row(ROW_SCORED, len, $urandom_range(1, len - 1), 1'b1);
         end
         drain();
         phase++;
      end

      if (fail_count == 0 && expected_points.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
